/* rtl/burst_pulse_sequencer_unit_defines.svh */
// Assertion helpers shared by the RTL of the burst pulse sequencer.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BURST_PULSE_SEQUENCER_UNIT_DEFINES_SVH
`define BURST_PULSE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bps_pkg.sv */
package bps_pkg;

  localparam int TABLE_DEPTH      = 16;
  localparam int TAB_AW           = $clog2(TABLE_DEPTH);
  localparam int DATA_W           = 16;
  localparam int MAX_SLOTS        = 16;
  localparam int TICKS_PER_SECOND = 1000000;

  localparam int TICKS_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int PW_W       = 16;
  localparam int OVH_W      = 10;
  localparam int ADV_W      = 10;
  localparam int FREQ_W     = 14;
  localparam int ACNT_W     = 5;
  localparam int SLOT_LEN_W = PW_W + 1;
  localparam int LEN_W      = (TICKS_W > SLOT_LEN_W) ? TICKS_W : SLOT_LEN_W;
  localparam int PROD_W     = SLOT_LEN_W + CNT_W;
  localparam int PL_W       = (TICKS_W > PROD_W) ? TICKS_W : PROD_W;
  localparam int DIVC_W     = $clog2(TICKS_W + 1);
  localparam int TCNT_W     = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FUNC_W     = 3;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 72;
  localparam int M_TUSER_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_STOP   = 3'd2,
    FUNC_WR_MUX = 3'd3,
    FUNC_WR_DAC = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_WIDTH   = 3'd0,
    CFG_SLOT_OVERHEAD = 3'd1,
    CFG_ADVANCE       = 3'd2,
    CFG_BURST_FREQ    = 3'd3,
    CFG_ACTIVE_COUNT  = 3'd4,
    CFG_PAUSE_PATTERN = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_MARK,
    S_OUT
  } state_e;

  // Power-on contents of the DAC table.
  localparam logic [DATA_W-1:0] DAC_RESET [TABLE_DEPTH] = '{
    16'd200,  16'd450,  16'd700,  16'd950,  16'd1200, 16'd1450, 16'd1700, 16'd1950,
    16'd2200, 16'd2450, 16'd2700, 16'd2950, 16'd3200, 16'd3450, 16'd3700, 16'd4000
  };

endpackage

/* rtl/burst_pulse_sequencer_unit.sv */
// Channel     | Dir | Handshake             | Payload
// ------------+-----+-----------------------+----------------------------------------------
// s_axis      | in  | tvalid/tready         | tuser: func; tdata: entry_index, entry_value
// m_axis      | out | tvalid/tready         | tuser: strobes; tdata: pattern, dac, status
// cfg         | in  | cfg_we_i (no wait)    | cfg_index_i selects register, cfg_wdata_i
//
// Steps: a plain tick, a table write or stop goes from accept through execute and output;
//   start and a tick that closes a slot also pass the mark step. A tick that closes the last
//   slot of a burst also runs the divider before the mark step: the pause length needs
//   TICKS_PER_SECOND / frequency, worked out one quotient bit a cycle by a restoring divider.
// Tables live in two 16-entry synchronous RAMs addressed at accept and read in execute;
//   valid bits make unwritten entries read as their power-on values, so no clearing pass is needed.
// Reset: stopped, in pause, all counters zero, registers at their documented defaults.
// Stalls: a finished item waits in the output register while the next item is accepted;
//   the sequencer holds in its output step only when that register is still full.
module burst_pulse_sequencer_unit
  import bps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] entry_index, [19:4] entry_value, [23:20] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] func
  input  logic [FUNC_W-1:0]     s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] mux_pattern, [31:16] dac_code, [32] transition_strobe, [33] burst_active,
  // [34] running, [66:35] transition_count, [71:67] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [0] preload_strobe, [1] immediate_strobe
  output logic [M_TUSER_W-1:0]  m_axis_tuser,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [PW_W-1:0]   pw_q;
  logic [OVH_W-1:0]  ovh_q;
  logic [ADV_W-1:0]  adv_q;
  logic [FREQ_W-1:0] freq_q;
  logic [ACNT_W-1:0] acnt_q;
  logic [DATA_W-1:0] pause_pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q        <= PW_W'(100);
      ovh_q       <= '0;
      adv_q       <= '0;
      freq_q      <= FREQ_W'(50);
      acnt_q      <= ACNT_W'(16);
      pause_pat_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PULSE_WIDTH:   pw_q        <= cfg_wdata_i[PW_W-1:0];
        CFG_SLOT_OVERHEAD: ovh_q       <= cfg_wdata_i[OVH_W-1:0];
        CFG_ADVANCE:       adv_q       <= cfg_wdata_i[ADV_W-1:0];
        CFG_BURST_FREQ:    freq_q      <= cfg_wdata_i[FREQ_W-1:0];
        CFG_ACTIVE_COUNT:  acnt_q      <= cfg_wdata_i[ACNT_W-1:0];
        CFG_PAUSE_PATTERN: pause_pat_q <= cfg_wdata_i[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the slot count to 1..MAX_SLOTS.
  logic [CNT_W-1:0]      eff_cnt;
  logic [SLOT_LEN_W-1:0] slot_len;

  always_comb begin
    if (acnt_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(acnt_q) > MAX_SLOTS) begin
      eff_cnt = CNT_W'(MAX_SLOTS);
    end else begin
      eff_cnt = CNT_W'(acnt_q);
    end
    slot_len = SLOT_LEN_W'(pw_q) + SLOT_LEN_W'(ovh_q);
  end

  // ------------------------------------------------------------------
  // Sequencer state
  // ------------------------------------------------------------------
  state_e state_q, state_d;

  logic              run_q, run_d;
  logic              pause_q, pause_d;
  logic [CNT_W-1:0]  slot_q, slot_d;
  logic [LEN_W-1:0]  elapsed_q, elapsed_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  mark_q, mark_d;
  logic [TCNT_W-1:0] tcount_q, tcount_d;

  // Item held while it is worked on.
  func_e             func_q;

  // Result fields built in the execute step.
  logic              res_pre_q, res_pre_d;
  logic              res_imm_q, res_imm_d;
  logic              res_trans_q, res_trans_d;
  logic [DATA_W-1:0] res_mux_q, res_mux_d;
  logic [DATA_W-1:0] res_dac_q, res_dac_d;

  // Length of the next interval and the active part of a burst.
  logic [LEN_W-1:0]  newlen_q, newlen_d;
  logic [PROD_W-1:0] prod_q;

  // Divider for the burst period.
  logic [FREQ_W-1:0]  div_den_q;
  logic [FREQ_W-1:0]  div_rem_q;
  logic [TICKS_W-1:0] div_dvd_q;
  logic [TICKS_W-1:0] div_quo_q;
  logic [DIVC_W-1:0]  div_cnt_q;

  // Output register.
  logic              out_valid_q;
  logic              out_pre_q, out_imm_q, out_trans_q, out_act_q, out_run_q;
  logic [DATA_W-1:0] out_mux_q, out_dac_q;
  logic [TCNT_W-1:0] out_cnt_q;

  // Handshake decode.
  logic  s_accept;
  logic  out_load;
  func_e s_func;
  logic  go_div;
  logic  go_mark;

  assign s_func   = func_e'(s_axis_tuser);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // ------------------------------------------------------------------
  // Tables: two RAMs, written at accept, read at accept for the next step
  // ------------------------------------------------------------------
  logic [CNT_W:0]              nxt_cur;
  logic [TAB_AW-1:0]           raddr;
  logic [TAB_AW-1:0]           raddr_q;
  logic [TAB_AW-1:0]           s_idx;
  logic [DATA_W-1:0]           s_val;
  logic                        mux_we, dac_we;
  logic [TABLE_DEPTH-1:0]      mux_vld_q, dac_vld_q;
  logic                        mux_rvld_q, dac_rvld_q;
  logic [DATA_W-1:0]           mux_rdata, dac_rdata;
  logic [DATA_W-1:0]           mux_rd, dac_rd;

  assign s_idx   = s_axis_tdata[TAB_AW-1:0];
  assign s_val   = s_axis_tdata[TAB_AW +: DATA_W];
  assign nxt_cur = {1'b0, slot_q} + 1'b1;
  assign mux_we  = s_accept && (s_func == FUNC_WR_MUX);
  assign dac_we  = s_accept && (s_func == FUNC_WR_DAC);

  // A pulse-slot tick may preload the next slot's entry; everything else needs entry 0.
  always_comb begin
    if ((s_func == FUNC_TICK) && !pause_q) begin
      raddr = TAB_AW'(32'(nxt_cur));
    end else begin
      raddr = '0;
    end
  end

  bps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_mux_ram (
    .clk_i   (clk_i),
    .we_i    (mux_we),
    .waddr_i (s_idx),
    .wdata_i (s_val),
    .raddr_i (raddr),
    .rdata_o (mux_rdata)
  );

  bps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_dac_ram (
    .clk_i   (clk_i),
    .we_i    (dac_we),
    .waddr_i (s_idx),
    .wdata_i (s_val),
    .raddr_i (raddr),
    .rdata_o (dac_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_vld_q <= '0;
      dac_vld_q <= '0;
    end else begin
      if (mux_we) begin
        mux_vld_q[s_idx] <= 1'b1;
      end
      if (dac_we) begin
        dac_vld_q[s_idx] <= 1'b1;
      end
    end
  end

  // Track the valid bit and address alongside the registered read.
  always_ff @(posedge clk_i) begin
    raddr_q    <= raddr;
    mux_rvld_q <= mux_vld_q[raddr];
    dac_rvld_q <= dac_vld_q[raddr];
  end

  assign mux_rd = mux_rvld_q ? mux_rdata : '0;
  assign dac_rd = dac_rvld_q ? dac_rdata : DAC_RESET[raddr_q];

  // ------------------------------------------------------------------
  // Control: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go_div) begin
          state_d = S_DIV;
        end else if (go_mark) begin
          state_d = S_MARK;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = S_MARK;
        end
      end
      S_MARK: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Control: outputs
  // ------------------------------------------------------------------
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  end

  // ------------------------------------------------------------------
  // Execute step: advance time or apply the command
  // ------------------------------------------------------------------
  logic [LEN_W-1:0] el_inc;
  logic             nxt_done;

  assign el_inc   = elapsed_q + 1'b1;
  assign nxt_done = nxt_cur >= {1'b0, eff_cnt};

  always_comb begin
    run_d       = run_q;
    pause_d     = pause_q;
    slot_d      = slot_q;
    elapsed_d   = elapsed_q;
    tcount_d    = tcount_q;
    res_pre_d   = 1'b0;
    res_imm_d   = 1'b0;
    res_trans_d = 1'b0;
    res_mux_d   = '0;
    res_dac_d   = '0;
    newlen_d    = LEN_W'(slot_len);
    go_div      = 1'b0;
    go_mark     = 1'b0;

    unique case (func_q)
      FUNC_TICK: begin
        if (run_q) begin
          elapsed_d = el_inc;
          if (el_inc == mark_q) begin
            res_pre_d = 1'b1;
            if (!pause_q && nxt_done) begin
              // Pause follows: drive the idle pattern.
              res_mux_d = pause_pat_q;
            end else begin
              res_mux_d = mux_rd;
              res_dac_d = dac_rd;
            end
          end
          if (el_inc >= len_q) begin
            res_trans_d = 1'b1;
            tcount_d    = tcount_q + 1'b1;
            if (!pause_q && nxt_done) begin
              pause_d = 1'b1;
              slot_d  = '0;
              go_div  = 1'b1;
            end else begin
              pause_d = 1'b0;
              slot_d  = pause_q ? '0 : CNT_W'(nxt_cur);
              go_mark = 1'b1;
            end
          end
        end
      end
      FUNC_START: begin
        if (!run_q) begin
          run_d     = 1'b1;
          pause_d   = 1'b0;
          slot_d    = '0;
          res_imm_d = 1'b1;
          res_mux_d = mux_rd;
          res_dac_d = dac_rd;
          go_mark   = 1'b1;
        end
      end
      FUNC_STOP: begin
        run_d     = 1'b0;
        pause_d   = 1'b1;
        slot_d    = '0;
        elapsed_d = '0;
        res_imm_d = 1'b1;
        res_mux_d = pause_pat_q;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Interval bounds: clamp the length, place the preload mark
  // ------------------------------------------------------------------
  logic [LEN_W-1:0] mk_len;
  logic [LEN_W-1:0] mk_mark;

  always_comb begin
    mk_len = (newlen_q == '0) ? LEN_W'(1) : newlen_q;
    if (mk_len > LEN_W'(adv_q)) begin
      mk_mark = mk_len - LEN_W'(adv_q);
    end else begin
      mk_mark = mk_len >> 1;
    end
    if (mk_mark == '0) begin
      mk_mark = LEN_W'(1);
    end
  end

  // Pause length from the divided period and the active part of the burst.
  logic [PL_W-1:0]   period_ext;
  logic [PL_W-1:0]   prod_ext;
  logic [LEN_W-1:0]  pause_len;
  logic [FREQ_W:0]   div_trial;
  logic              div_take;

  always_comb begin
    period_ext = PL_W'(div_quo_q);
    prod_ext   = PL_W'(prod_q);
    pause_len  = (period_ext > prod_ext) ? LEN_W'(period_ext - prod_ext) : '0;
    div_trial  = {div_rem_q, div_dvd_q[TICKS_W-1]};
    div_take   = div_trial >= {1'b0, div_den_q};
  end

  // ------------------------------------------------------------------
  // Control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= 1'b0;
      pause_q     <= 1'b1;
      slot_q      <= '0;
      elapsed_q   <= '0;
      len_q       <= '0;
      mark_q      <= '0;
      tcount_q    <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        run_q     <= run_d;
        pause_q   <= pause_d;
        slot_q    <= slot_d;
        elapsed_q <= elapsed_d;
        tcount_q  <= tcount_d;
        if (func_q == FUNC_STOP) begin
          len_q  <= '0;
          mark_q <= '0;
        end
        if (go_div) begin
          div_cnt_q <= DIVC_W'(TICKS_W);
        end
      end
      if ((state_q == S_DIV) && (div_cnt_q != '0)) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      if (state_q == S_MARK) begin
        len_q     <= mk_len;
        mark_q    <= mk_mark;
        elapsed_q <= '0;
      end
      // Hold the result until the sink takes it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Payload registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q <= s_func;
    end
    if (state_q == S_EXEC) begin
      res_pre_q   <= res_pre_d;
      res_imm_q   <= res_imm_d;
      res_trans_q <= res_trans_d;
      res_mux_q   <= res_mux_d;
      res_dac_q   <= res_dac_d;
      newlen_q    <= newlen_d;
      prod_q      <= PROD_W'(slot_len) * PROD_W'(eff_cnt);
      div_den_q   <= (freq_q == '0) ? FREQ_W'(1) : freq_q;
      div_rem_q   <= '0;
      div_dvd_q   <= TICKS_W'(TICKS_PER_SECOND);
      div_quo_q   <= '0;
    end
    if (state_q == S_DIV) begin
      if (div_cnt_q != '0) begin
        // One restoring step per cycle, most significant bit first.
        div_rem_q <= div_take ? FREQ_W'(div_trial - {1'b0, div_den_q})
                              : FREQ_W'(div_trial);
        div_dvd_q <= div_dvd_q << 1;
        div_quo_q <= {div_quo_q[TICKS_W-2:0], div_take};
      end else begin
        newlen_q <= pause_len;
      end
    end
    if (out_load) begin
      out_pre_q   <= res_pre_q;
      out_imm_q   <= res_imm_q;
      out_trans_q <= res_trans_q;
      out_mux_q   <= res_mux_q;
      out_dac_q   <= res_dac_q;
      out_act_q   <= run_q && !pause_q;
      out_run_q   <= run_q;
      out_cnt_q   <= tcount_q;
    end
  end

  // Table writes carry no time; the index and value are consumed at accept.
  logic wr_item;
  assign wr_item = (func_q == FUNC_WR_MUX) || (func_q == FUNC_WR_DAC);

  // ------------------------------------------------------------------
  // Ports
  // ------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_imm_q, out_pre_q};
  assign m_axis_tdata  = {{(M_TDATA_W - TCNT_W - 3 - 2 * DATA_W){1'b0}},
                          out_cnt_q, out_run_q, out_act_q, out_trans_q,
                          out_dac_q, out_mux_q};

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  logic idle_run;
  logic mark_ok;
  logic wr_exec;
  logic time_moved;

  assign idle_run   = run_q && (state_q == S_IDLE);
  assign mark_ok    = (mark_q != '0) && (mark_q <= len_q);
  assign wr_exec    = (state_q == S_EXEC) && wr_item;
  assign time_moved = go_mark || go_div || (elapsed_d != elapsed_q);

`include "burst_pulse_sequencer_unit_defines.svh"

  `BPS_ASSERT_IMP(a_elapsed_in_interval, idle_run, elapsed_q < len_q, "elapsed past interval end")
  `BPS_ASSERT_IMP(a_mark_in_interval, idle_run, mark_ok, "preload mark outside interval")
  `BPS_ASSERT_NXT(a_count_on_exec, state_q != S_EXEC, $stable(tcount_q), "count moved")
  `BPS_ASSERT_IMP(a_one_strobe, m_axis_tvalid, !(&m_axis_tuser), "two strobes at once")
  `BPS_ASSERT_IMP(a_write_keeps_time, wr_exec, !time_moved, "table write advanced time")

endmodule

/* rtl/bps_ram.sv */
module bps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sim/testbench.sv */
`default_nettype none

// Self-checking bench for burst_pulse_sequencer_unit.
//
// Commands and ticks go in on the s_axis stream. Each one yields exactly one output item
// on m_axis. The bench keeps its own copy of the sequencer state, works out the output item
// for every accepted command, and checks the m_axis items against those expectations in
// order. The register file is rewritten only while the block is drained.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int IDLE_PCT     = 11;      // chance in a hundred that a side idles in a cycle
  localparam int CYCLE_LIMIT  = 400000;  // many times the slowest correct run
  localparam int DRAIN_CYCLES = 50;      // outlasts the slowest item, a burst-closing tick
  localparam int FUNC_CODES   = 1 << FUNC_W;
  localparam int NUM_PHASES   = 10;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TAB_AW-1:0] idx;
    logic [DATA_W-1:0] value;
  } pulse_cmd_t;

  typedef struct packed {
    logic              preload;
    logic              immediate;
    logic [DATA_W-1:0] mux;
    logic [DATA_W-1:0] dac;
    logic              transition;
    logic              active;
    logic              run;
    logic [TCNT_W-1:0] transitions;
  } pulse_out_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  burst_pulse_sequencer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Register copies, as the block holds them after masking to their widths.
  int unsigned pulse_width;
  int unsigned slot_overhead;
  int unsigned advance;
  int unsigned burst_freq;
  int unsigned active_cnt;
  int unsigned pause_pat;

  // Sequencer state copy.
  bit                seq_running;
  bit                seq_in_pause;
  int unsigned       slot_idx;
  int unsigned       elapsed;
  int unsigned       interval_len;
  int unsigned       preload_at;
  logic [DATA_W-1:0] mux_tab [TABLE_DEPTH];
  logic [DATA_W-1:0] dac_tab [TABLE_DEPTH];
  logic [TCNT_W-1:0] trans_total;

  pulse_cmd_t cmd_backlog [$];   // items waiting for the driver
  pulse_out_t outputs_due [$];   // predicted output items, oldest first
  pulse_cmd_t held;              // item currently offered on s_axis

  bit steady;                    // set: neither side idles
  int errors;
  int cycles;
  int n_accepted;
  int n_checked;
  int n_preload;
  int n_transition;
  int n_immediate;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Count zero means one slot; anything above the table size is clipped.
  function automatic int unsigned slots_in_burst();
    if (active_cnt == 0) return 1;
    if (active_cnt > MAX_SLOTS) return MAX_SLOTS;
    return active_cnt;
  endfunction

  function automatic int unsigned slot_ticks();
    return pulse_width + slot_overhead;
  endfunction

  // Start a slot or pause interval. A zero length still takes one tick, and the preload
  // point never sits at zero, so it may coincide with the closing tick.
  function automatic void open_interval(int unsigned len);
    int unsigned mark;
    if (len == 0) len = 1;
    mark = (len > advance) ? len - advance : len / 2;
    if (mark == 0) mark = 1;
    interval_len = len;
    preload_at   = mark;
    elapsed      = 0;
  endfunction

  // Apply one accepted item to the state copy and return the output item it yields.
  function automatic pulse_out_t next_pulse_outputs(pulse_cmd_t cmd);
    pulse_out_t  r;
    int unsigned period;
    int unsigned busy;
    int unsigned nxt;
    r = '0;
    case (cmd.func)
      FUNC_TICK: begin
        // Time only advances while started.
        if (seq_running) begin
          elapsed++;
          if (elapsed == preload_at) begin
            r.preload = 1'b1;
            nxt = slot_idx + 1;
            if (seq_in_pause) begin
              // Pause about to end: first slot of the next burst.
              r.mux = mux_tab[0];
              r.dac = dac_tab[0];
            end else if (nxt >= slots_in_burst()) begin
              // Last slot: the pause follows.
              r.mux = pause_pat[DATA_W-1:0];
              r.dac = '0;
            end else begin
              r.mux = mux_tab[nxt % TABLE_DEPTH];
              r.dac = dac_tab[nxt % TABLE_DEPTH];
            end
          end
          if (elapsed >= interval_len) begin
            r.transition = 1'b1;
            trans_total++;
            if (!seq_in_pause) begin
              slot_idx++;
              // A count lowered mid-burst also ends the burst here.
              if (slot_idx >= slots_in_burst()) begin
                seq_in_pause = 1'b1;
                slot_idx     = 0;
                period = TICKS_PER_SECOND / ((burst_freq == 0) ? 1 : burst_freq);
                busy   = slot_ticks() * slots_in_burst();
                // An overrun burst gets a zero pause, which still lasts one tick.
                open_interval((period > busy) ? period - busy : 0);
              end else begin
                open_interval(slot_ticks());
              end
            end else begin
              seq_in_pause = 1'b0;
              slot_idx     = 0;
              open_interval(slot_ticks());
            end
          end
        end
      end
      FUNC_START: begin
        // A second start while running is dropped without a strobe.
        if (!seq_running) begin
          seq_running  = 1'b1;
          seq_in_pause = 1'b0;
          slot_idx     = 0;
          r.immediate  = 1'b1;
          r.mux        = mux_tab[0];
          r.dac        = dac_tab[0];
          open_interval(slot_ticks());
        end
      end
      FUNC_STOP: begin
        // Stop always strobes the pause pattern, stopped or not.
        seq_running  = 1'b0;
        seq_in_pause = 1'b1;
        slot_idx     = 0;
        elapsed      = 0;
        interval_len = 0;
        preload_at   = 0;
        r.immediate  = 1'b1;
        r.mux        = pause_pat[DATA_W-1:0];
        r.dac        = '0;
      end
      FUNC_WR_MUX: mux_tab[cmd.idx] = cmd.value;
      FUNC_WR_DAC: dac_tab[cmd.idx] = cmd.value;
      default: ;  // unused codes change nothing
    endcase
    r.active      = seq_running && !seq_in_pause;
    r.run         = seq_running;
    r.transitions = trans_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Driver: offer the next backlog item once the current one is taken, with random gaps.
  always @(posedge clk_i) begin
    logic take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      take = s_axis_tvalid && s_axis_tready;
      // Predict on acceptance, before the held item is replaced.
      if (take) begin
        outputs_due.push_back(next_pulse_outputs(held));
        n_accepted++;
      end
      if (!s_axis_tvalid || take) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          held = cmd_backlog.pop_front();
          s_axis_tuser  <= held.func;
          s_axis_tdata  <= {{(S_TDATA_W - DATA_W - TAB_AW){1'b0}}, held.value, held.idx};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted output item against the oldest prediction.
  always @(posedge clk_i) begin
    pulse_out_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outputs_due.size() == 0) begin
          $error("output item with no prediction pending");
          errors++;
        end else begin
          want = outputs_due.pop_front();
          n_checked++;
          if (want.preload) n_preload++;
          if (want.transition) n_transition++;
          if (want.immediate) n_immediate++;
          check_field("preload_strobe", want.preload, m_axis_tuser[0]);
          check_field("immediate_strobe", want.immediate, m_axis_tuser[1]);
          check_field("mux_pattern", want.mux, m_axis_tdata[15:0]);
          check_field("dac_code", want.dac, m_axis_tdata[31:16]);
          check_field("transition_strobe", want.transition, m_axis_tdata[32]);
          check_field("burst_active", want.active, m_axis_tdata[33]);
          check_field("running", want.run, m_axis_tdata[34]);
          check_field("transition_count", want.transitions, m_axis_tdata[66:35]);
        end
      end
      m_axis_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions open", cycles, outputs_due.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Write one register on the port and in the copy.
  task automatic put_reg(cfg_reg_e r, int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= CFG_DATA_W'(v);
    case (r)
      CFG_PULSE_WIDTH:   pulse_width   = v[PW_W-1:0];
      CFG_SLOT_OVERHEAD: slot_overhead = v[OVH_W-1:0];
      CFG_ADVANCE:       advance       = v[ADV_W-1:0];
      CFG_BURST_FREQ:    burst_freq    = v[FREQ_W-1:0];
      CFG_ACTIVE_COUNT:  active_cnt    = v[ACNT_W-1:0];
      CFG_PAUSE_PATTERN: pause_pat     = v[DATA_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite the whole register file; call only with the block drained.
  task automatic load_settings(int unsigned pw, int unsigned ovh, int unsigned adv,
                               int unsigned freq, int unsigned cnt, int unsigned pat);
    put_reg(CFG_PULSE_WIDTH, pw);
    put_reg(CFG_SLOT_OVERHEAD, ovh);
    put_reg(CFG_ADVANCE, adv);
    put_reg(CFG_BURST_FREQ, freq);
    put_reg(CFG_ACTIVE_COUNT, cnt);
    put_reg(CFG_PAUSE_PATTERN, pat);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic post(logic [FUNC_W-1:0] func, int unsigned idx, int unsigned value);
    pulse_cmd_t c;
    c.func  = func;
    c.idx   = idx[TAB_AW-1:0];
    c.value = value[DATA_W-1:0];
    cmd_backlog.push_back(c);
  endtask

  // Hold until nothing is queued, offered or outstanding; sample away from the clock edge.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || outputs_due.size() != 0);
  endtask

  // Queue one phase of random traffic. Mostly ticks while running, with table writes
  // mixed in and rare stops; when stopped, mostly a start to get going again. Items the
  // block ignores do not count toward the quota.
  task automatic queue_phase(int quota);
    int unsigned       roll;
    int                done;
    bit                on;
    bit                counts;
    logic [FUNC_W-1:0] f;
    done = 0;
    on   = seq_running;
    @(negedge clk_i);
    while (done < quota) begin
      roll = $urandom_range(0, 999);
      if (on) begin
        if (roll < 900)      f = FUNC_TICK;
        else if (roll < 940) f = FUNC_WR_MUX;
        else if (roll < 980) f = FUNC_WR_DAC;
        else if (roll < 988) f = FUNC_START;
        else if (roll < 996) f = FUNC_W'($urandom_range(FUNC_WR_DAC + 1, FUNC_CODES - 1));
        else begin
          f  = FUNC_STOP;
          on = 1'b0;
        end
        counts = (f != FUNC_START) && (f <= FUNC_WR_DAC);
      end else begin
        if (roll < 600) begin
          f  = FUNC_START;
          on = 1'b1;
        end
        else if (roll < 750) f = FUNC_TICK;
        else if (roll < 800) f = FUNC_WR_MUX;
        else if (roll < 850) f = FUNC_WR_DAC;
        else if (roll < 920) f = FUNC_STOP;
        else                 f = FUNC_W'($urandom_range(FUNC_WR_DAC + 1, FUNC_CODES - 1));
        counts = (f != FUNC_TICK) && (f <= FUNC_WR_DAC);
      end
      post(f, $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, (1 << DATA_W) - 1));
      if (counts) done++;
    end
  endtask

  initial begin
    int unsigned pw, ovh, adv, freq, cnt, pat;
    int          quota;

    // Power-on state of the copy.
    pulse_width   = 100;
    slot_overhead = 0;
    advance       = 0;
    burst_freq    = 50;
    active_cnt    = 16;
    pause_pat     = 0;
    seq_running   = 1'b0;
    seq_in_pause  = 1'b1;
    slot_idx      = 0;
    elapsed       = 0;
    interval_len  = 0;
    preload_at    = 0;
    trans_total   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      mux_tab[i] = '0;
      dac_tab[i] = (i == TABLE_DEPTH - 1) ? 16'd4000 : DATA_W'(200 + 250 * i);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-tick slots, so preload and transition land on the same tick; a short
    // three-slot burst followed by the start of a pause.
    load_settings(0, 0, 0, 10000, 3, 16'hFFFF);
    @(negedge clk_i);
    post(FUNC_STOP, 0, 0);                           // stop while already stopped
    post(FUNC_TICK, 0, 0);                           // tick while stopped
    post(FUNC_WR_MUX, 0, 16'hFFFF);
    post(FUNC_WR_MUX, TABLE_DEPTH - 1, 16'h0000);
    post(FUNC_WR_MUX, 1, 16'h5AA5);
    post(FUNC_WR_DAC, 0, 16'hFFFF);
    post(FUNC_WR_DAC, TABLE_DEPTH - 1, 16'h0000);
    for (int c = FUNC_WR_DAC + 1; c < FUNC_CODES; c++)   // unused codes
      post(FUNC_W'(c), $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 65535));
    post(FUNC_START, 0, 0);
    post(FUNC_START, 0, 0);                          // start while running
    repeat (5) post(FUNC_TICK, 0, 0);                // close the burst, enter the pause
    post(FUNC_WR_DAC, 2, $urandom_range(0, 65535));  // table write while running
    post(FUNC_STOP, 0, 0);
    post(FUNC_STOP, 0, 0);
    post(FUNC_START, 0, 0);
    repeat (2) post(FUNC_TICK, 0, 0);
    wait_idle();

    // Random phases, each under its own settings; extremes first, then random short periods.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quota = 115;
      pat   = $urandom_range(0, 65535);
      case (p)
        // Overrun burst: zero pause, preload at half length since the lead exceeds it.
        0: begin pw = 7; ovh = 0; adv = 1023; freq = 10000; cnt = 16; end
        // Count zero runs as one slot.
        1: begin pw = 2; ovh = 1; adv = 1; freq = 10000; cnt = 0; end
        // Widest slots, zero frequency, count above the table size.
        2: begin pw = 65535; ovh = 1023; adv = 1023; freq = 0; cnt = 31; quota = 40; end
        // Lowest legal frequency: one short slot, then a very long pause.
        3: begin pw = 0; ovh = 0; adv = 0; freq = 1; cnt = 1; quota = 40; end
        default: begin
          pw   = $urandom_range(0, 10);
          ovh  = $urandom_range(0, 3);
          adv  = $urandom_range(0, 6);
          freq = $urandom_range(8000, 10000);
          cnt  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        end
      endcase
      load_settings(pw, ovh, adv, freq, cnt, pat);
      steady = (p == 4);   // one phase runs back to back with no gaps
      queue_phase(quota);
      wait_idle();
      steady = 1'b0;
    end

    // Let any stray output item show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d commands and ticks under %0d register settings, %0d outputs checked.",
             n_accepted, NUM_PHASES + 1, n_checked);
    $display("Seen %0d preload, %0d transition and %0d immediate strobes.",
             n_preload, n_transition, n_immediate);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* burst_pulse_sequencer_unit.f */
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_ram.sv
rtl/burst_pulse_sequencer_unit.sv
sim/testbench.sv
